@@ src/srsw_pkg.sv @@
// Shared types and codes for the selective-repeat sender window block.
// No dependencies; the top level imports this package.
package srsw_pkg;

  // Fixed width of the sequence-carrying ports.
  localparam int FIELD_W = 16;
  // Most results one item may produce; also caps the effective window.
  localparam int MAX_RES = 16;
  // Width of window size, retransmit count and limit.
  localparam int CNT_W = 5;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_OFFER = 2'd0;
  localparam func_t FUNC_ACK   = 2'd1;
  localparam func_t FUNC_TICK  = 2'd2;

  typedef logic [1:0] action_t;
  localparam action_t ACT_NONE = 2'd0;
  localparam action_t ACT_SEND = 2'd1;
  localparam action_t ACT_RETX = 2'd2;
  localparam action_t ACT_DONE = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WINDOW_SIZE = 2'd0;
  localparam cfg_idx_t CFG_TIMEOUT     = 2'd1;

  localparam logic [CNT_W-1:0]   RESET_WINDOW_SIZE = 5'd10;
  localparam logic [FIELD_W-1:0] RESET_TIMEOUT     = 16'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SLIDE_RD,
    S_SLIDE_CMP,
    S_RTX_RD,
    S_RTX_CMP,
    S_RTX_FLUSH
  } state_t;

endpackage

@@ src/srsw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/srsw_slot_unit.sv @@
// Shared slot arithmetic: sequence plus offset, its window slot, and the tag compare.
// No package dependencies; instantiated once by the top level.
module srsw_slot_unit #(
  parameter int SEQ_BITS = 16,
  parameter int WIN_MAX = 16,
  localparam int IW = $clog2(WIN_MAX)
) (
  input  logic [SEQ_BITS-1:0] base_seq,
  input  logic [IW-1:0]       base_slot,
  input  logic [IW-1:0]       off,
  output logic [SEQ_BITS-1:0] sum_seq,
  output logic [IW-1:0]       sum_slot,
  input  logic [SEQ_BITS-1:0] tag_q,
  input  logic                tag_vld,
  input  logic [SEQ_BITS-1:0] ref_seq,
  output logic                match
);

  localparam logic [IW:0] WRAP = (IW+1)'(WIN_MAX);

  logic [SEQ_BITS:0] sum_full;
  logic [IW:0]       slot_sum;

  // The offset is always below WIN_MAX, so one conditional subtract keeps the
  // slot in range. If the sequence itself wraps, the new sequence is smaller
  // than the offset and is its own slot.
  assign sum_full = {1'b0, base_seq} + (SEQ_BITS+1)'(off);
  assign slot_sum = {1'b0, base_slot} + {1'b0, off};
  assign sum_seq  = sum_full[SEQ_BITS-1:0];

  always_comb begin
    if (sum_full[SEQ_BITS]) begin
      sum_slot = IW'(sum_full[SEQ_BITS-1:0]);
    end else if (slot_sum >= WRAP) begin
      sum_slot = IW'(slot_sum - WRAP);
    end else begin
      sum_slot = IW'(slot_sum);
    end
  end

  assign match = tag_vld && (tag_q == ref_seq);

endmodule

@@ src/selective_repeat_sender_window_unit.sv @@
// Top level of the selective-repeat sender window: sequencer, window state and tag store.
// Depends on srsw_pkg, srsw_slot_unit and srsw_ram.
//
// Offers, plain acks, idle ticks and ignored items take only the EXEC state: busy is high
// for one cycle, and the next item may be accepted while their result beat is out.
// An ack at the base then slides through SLIDE_RD and SLIDE_CMP; a timed-out tick scans
// its window through RTX_RD, RTX_CMP and RTX_FLUSH, the tag RAM read port scanning one slot per cycle.
// Reset is synchronous and active low; tag valid flops clear at once, no clearing pass.
// The receiver cannot stall: each result beat is on the out_ ports for exactly one cycle.
module selective_repeat_sender_window_unit #(
  parameter int WIN_MAX = 16,
  parameter int SEQ_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Command channel.
  input  logic                                 start,
  output logic                                 busy,
  input  srsw_pkg::func_t                      in_func,
  input  logic [srsw_pkg::FIELD_W-1:0]         in_ack_seq,
  input  logic                                 in_is_final,
  // Result channel.
  output logic                                 out_strobe,
  output srsw_pkg::action_t                    out_action,
  output logic [srsw_pkg::FIELD_W-1:0]         out_seq,
  output logic                                 out_route,
  output logic [srsw_pkg::FIELD_W-1:0]         out_window_base,
  output logic                                 out_run_end,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  srsw_pkg::cfg_idx_t                   cfg_index,
  input  logic [srsw_pkg::FIELD_W-1:0]         cfg_data
);

  import srsw_pkg::*;

  localparam int IW = $clog2(WIN_MAX);
  // The effective window never exceeds the slot count or the result limit.
  localparam int WEFF = (WIN_MAX < MAX_RES) ? WIN_MAX : MAX_RES;

  // Slot of the sequence after s, given the slot of s. A wrap of the sequence
  // space restarts at slot zero even when WIN_MAX does not divide it.
  function automatic logic [IW-1:0] slot_inc(input logic [SEQ_BITS-1:0] s,
                                             input logic [IW-1:0] sl);
    logic [IW-1:0] r;
    if (&s) begin
      r = '0;
    end else if (sl == IW'(WIN_MAX - 1)) begin
      r = '0;
    end else begin
      r = sl + 1'b1;
    end
    return r;
  endfunction

  // Sequencer state.
  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CNT_W-1:0]   win_size_r;
  logic [FIELD_W-1:0] timeout_r;

  // Window state.
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SEQ_BITS-1:0] next_r, next_nxt;
  logic [IW-1:0]       base_slot_r, base_slot_nxt;
  logic [IW-1:0]       next_slot_r, next_slot_nxt;
  logic                final_known_r, final_known_nxt;
  logic                finished_r, finished_nxt;
  logic [FIELD_W-1:0]  timer_r, timer_nxt;
  // A cleared valid bit means the slot holds no ack; the RAM keeps the acked sequence.
  logic [WIN_MAX-1:0]  tag_vld_r, tag_vld_nxt;

  // Latched command beat.
  func_t               func_r;
  logic [SEQ_BITS-1:0] ack_r;
  logic                is_final_r;

  // Retransmit scan.
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic [SEQ_BITS-1:0] cmp_seq_r, cmp_seq_nxt;
  logic [IW-1:0]       cmp_slot_r, cmp_slot_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [SEQ_BITS-1:0] pend_seq_r, pend_seq_nxt;

  // Result registers.
  logic                out_strobe_r, out_strobe_nxt;
  action_t             out_action_r, out_action_nxt;
  logic [FIELD_W-1:0]  out_seq_r, out_seq_nxt;
  logic                out_route_r, out_route_nxt;
  logic [FIELD_W-1:0]  out_window_base_r, out_window_base_nxt;
  logic                out_run_end_r, out_run_end_nxt;

  // Derived values.
  logic [CNT_W-1:0]    w_eff;
  logic [SEQ_BITS-1:0] outstanding;
  logic [CNT_W-1:0]    lim;
  logic [SEQ_BITS-1:0] ack_off;
  logic                ack_ok;
  logic [FIELD_W-1:0]  timer_inc;
  logic                timeout;
  logic                done;
  logic                accept;
  logic                slide_hit;
  logic                k_more;

  // Shared unit and tag RAM connections.
  logic [IW-1:0]       u_off;
  logic [SEQ_BITS-1:0] u_sum_seq;
  logic [IW-1:0]       u_sum_slot;
  logic                u_tag_vld;
  logic [SEQ_BITS-1:0] u_ref_seq;
  logic                u_match;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [SEQ_BITS-1:0] ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [SEQ_BITS-1:0] ram_q;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Window size zero behaves as one; large values clamp to WEFF, the smaller of slot count and result limit.
  always_comb begin
    if (win_size_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (win_size_r > CNT_W'(WEFF)) begin
      w_eff = CNT_W'(WEFF);
    end else begin
      w_eff = win_size_r;
    end
  end

  assign outstanding = next_r - base_r;
  assign lim = (outstanding < SEQ_BITS'(w_eff)) ? CNT_W'(outstanding) : w_eff;
  assign ack_off = ack_r - base_r;
  // An ack counts only inside the window and for a sequence already sent.
  assign ack_ok = (ack_off < SEQ_BITS'(w_eff)) && (ack_off < outstanding);
  assign timer_inc = (&timer_r) ? timer_r : timer_r + 1'b1;
  // A timeout setting of zero fires on every tick, exactly as a setting of one.
  assign timeout = (timer_inc >= timeout_r);
  assign done = final_known_r && (base_r == next_r);
  assign slide_hit = (base_r != next_r) && u_match;
  assign k_more = (k_r < lim_r);

  // The shared unit resolves the slot of the ack in EXEC and of each scanned
  // sequence during retransmit; its compare serves both the slide and the scan.
  assign u_off     = (state_r == S_EXEC) ? IW'(ack_off) : IW'(k_r);
  assign u_ref_seq = (state_r == S_SLIDE_CMP) ? base_r : cmp_seq_r;
  assign u_tag_vld = (state_r == S_SLIDE_CMP) ? tag_vld_r[base_slot_r]
                                              : tag_vld_r[cmp_slot_r];

  srsw_slot_unit #(
    .SEQ_BITS (SEQ_BITS),
    .WIN_MAX  (WIN_MAX)
  ) u_slot (
    .base_seq  (base_r),
    .base_slot (base_slot_r),
    .off       (u_off),
    .sum_seq   (u_sum_seq),
    .sum_slot  (u_sum_slot),
    .tag_q     (ram_q),
    .tag_vld   (u_tag_vld),
    .ref_seq   (u_ref_seq),
    .match     (u_match)
  );

  srsw_ram #(
    .WIDTH (SEQ_BITS),
    .DEPTH (WIN_MAX)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (!finished_r) begin
          case (func_r)
            FUNC_ACK: begin
              if (ack_ok && (ack_r == base_r)) begin
                state_nxt = S_SLIDE_RD;
              end
            end
            FUNC_TICK: begin
              if (timeout && (lim != '0)) begin
                state_nxt = S_RTX_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SLIDE_RD:  state_nxt = S_SLIDE_CMP;
      S_SLIDE_CMP: begin
        if (!slide_hit) begin
          state_nxt = S_IDLE;
        end
      end
      S_RTX_RD:    state_nxt = S_RTX_CMP;
      S_RTX_CMP: begin
        if (!k_more) begin
          state_nxt = S_RTX_FLUSH;
        end
      end
      S_RTX_FLUSH: state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result outputs of the sequencer.
  always_comb begin
    base_nxt            = base_r;
    next_nxt            = next_r;
    base_slot_nxt       = base_slot_r;
    next_slot_nxt       = next_slot_r;
    final_known_nxt     = final_known_r;
    finished_nxt        = finished_r;
    timer_nxt           = timer_r;
    tag_vld_nxt         = tag_vld_r;
    k_nxt               = k_r;
    lim_nxt             = lim_r;
    cmp_seq_nxt         = cmp_seq_r;
    cmp_slot_nxt        = cmp_slot_r;
    pend_vld_nxt        = pend_vld_r;
    pend_seq_nxt        = pend_seq_r;
    out_strobe_nxt      = 1'b0;
    out_action_nxt      = out_action_r;
    out_seq_nxt         = out_seq_r;
    out_route_nxt       = out_route_r;
    out_window_base_nxt = out_window_base_r;
    out_run_end_nxt     = out_run_end_r;
    ram_we              = 1'b0;
    ram_waddr           = u_sum_slot;
    ram_wdata           = ack_r;
    ram_raddr           = base_slot_r;

    case (state_r)
      S_EXEC: begin
        // Every path here that ends the item emits a single closing beat.
        out_strobe_nxt      = 1'b1;
        out_action_nxt      = ACT_NONE;
        out_seq_nxt         = '0;
        out_route_nxt       = 1'b0;
        out_window_base_nxt = FIELD_W'(base_r);
        out_run_end_nxt     = 1'b1;
        pend_vld_nxt        = 1'b0;
        k_nxt               = '0;
        lim_nxt             = lim;
        if (!finished_r) begin
          case (func_r)
            FUNC_OFFER: begin
              if (!final_known_r && (outstanding < SEQ_BITS'(w_eff))) begin
                tag_vld_nxt[next_slot_r] = 1'b0;
                next_nxt      = next_r + 1'b1;
                next_slot_nxt = slot_inc(next_r, next_slot_r);
                if (is_final_r) begin
                  final_known_nxt = 1'b1;
                end
                timer_nxt      = '0;
                out_action_nxt = ACT_SEND;
                out_seq_nxt    = FIELD_W'(next_r);
                out_route_nxt  = next_r[0];
              end
            end
            FUNC_ACK: begin
              if (ack_ok) begin
                ram_we                  = 1'b1;
                tag_vld_nxt[u_sum_slot] = 1'b1;
              end
              if (ack_ok && (ack_r == base_r)) begin
                // The result follows once the slide has run.
                out_strobe_nxt = 1'b0;
              end else if (done) begin
                finished_nxt   = 1'b1;
                out_action_nxt = ACT_DONE;
              end
            end
            FUNC_TICK: begin
              timer_nxt = timer_inc;
              if (timeout) begin
                timer_nxt = '0;
                if (lim != '0) begin
                  out_strobe_nxt = 1'b0;
                end
              end
            end
            default: begin
              out_action_nxt = ACT_NONE;
            end
          endcase
        end
      end
      S_SLIDE_RD: begin
        ram_raddr = base_slot_r;
      end
      S_SLIDE_CMP: begin
        if (slide_hit) begin
          tag_vld_nxt[base_slot_r] = 1'b0;
          base_nxt      = base_r + 1'b1;
          base_slot_nxt = slot_inc(base_r, base_slot_r);
          ram_raddr     = base_slot_nxt;
        end else begin
          out_strobe_nxt      = 1'b1;
          out_action_nxt      = done ? ACT_DONE : ACT_NONE;
          out_seq_nxt         = '0;
          out_route_nxt       = 1'b0;
          out_window_base_nxt = FIELD_W'(base_r);
          out_run_end_nxt     = 1'b1;
          if (done) begin
            finished_nxt = 1'b1;
          end
        end
      end
      S_RTX_RD: begin
        ram_raddr    = u_sum_slot;
        cmp_seq_nxt  = u_sum_seq;
        cmp_slot_nxt = u_sum_slot;
        k_nxt        = k_r + 1'b1;
      end
      S_RTX_CMP: begin
        // A miss is held in pend_seq until the next miss or the flush, so the last beat can carry run_end.
        if (!u_match) begin
          if (pend_vld_r) begin
            out_strobe_nxt      = 1'b1;
            out_action_nxt      = ACT_RETX;
            out_seq_nxt         = FIELD_W'(pend_seq_r);
            out_route_nxt       = pend_seq_r[0];
            out_window_base_nxt = FIELD_W'(base_r);
            out_run_end_nxt     = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_seq_nxt = cmp_seq_r;
        end
        if (k_more) begin
          ram_raddr    = u_sum_slot;
          cmp_seq_nxt  = u_sum_seq;
          cmp_slot_nxt = u_sum_slot;
          k_nxt        = k_r + 1'b1;
        end
      end
      S_RTX_FLUSH: begin
        out_strobe_nxt      = 1'b1;
        out_action_nxt      = pend_vld_r ? ACT_RETX : ACT_NONE;
        out_seq_nxt         = pend_vld_r ? FIELD_W'(pend_seq_r) : '0;
        out_route_nxt       = pend_vld_r && pend_seq_r[0];
        out_window_base_nxt = FIELD_W'(base_r);
        out_run_end_nxt     = 1'b1;
      end
      default: begin
        ram_raddr = base_slot_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      win_size_r    <= RESET_WINDOW_SIZE;
      timeout_r     <= RESET_TIMEOUT;
      base_r        <= '0;
      next_r        <= '0;
      base_slot_r   <= '0;
      next_slot_r   <= '0;
      final_known_r <= 1'b0;
      finished_r    <= 1'b0;
      timer_r       <= '0;
      tag_vld_r     <= '0;
      k_r           <= '0;
      lim_r         <= '0;
      pend_vld_r    <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      base_r        <= base_nxt;
      next_r        <= next_nxt;
      base_slot_r   <= base_slot_nxt;
      next_slot_r   <= next_slot_nxt;
      final_known_r <= final_known_nxt;
      finished_r    <= finished_nxt;
      timer_r       <= timer_nxt;
      tag_vld_r     <= tag_vld_nxt;
      k_r           <= k_nxt;
      lim_r         <= lim_nxt;
      pend_vld_r    <= pend_vld_nxt;
      out_strobe_r  <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_SIZE: win_size_r <= cfg_data[CNT_W-1:0];
          CFG_TIMEOUT:     timeout_r  <= cfg_data;
          default:         win_size_r <= win_size_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      ack_r      <= SEQ_BITS'(in_ack_seq);
      is_final_r <= in_is_final;
    end
    cmp_seq_r         <= cmp_seq_nxt;
    cmp_slot_r        <= cmp_slot_nxt;
    pend_seq_r        <= pend_seq_nxt;
    out_action_r      <= out_action_nxt;
    out_seq_r         <= out_seq_nxt;
    out_route_r       <= out_route_nxt;
    out_window_base_r <= out_window_base_nxt;
    out_run_end_r     <= out_run_end_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_action      = out_action_r;
  assign out_seq         = out_seq_r;
  assign out_route       = out_route_r;
  assign out_window_base = out_window_base_r;
  assign out_run_end     = out_run_end_r;

  // A result beat only ever follows a cycle of work on an item.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r != S_IDLE))
    else $error("result beat without an item in progress");

  // Leaving work always closes the item with a run_end beat.
  a_close_with_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_nxt == S_IDLE) |=> (out_strobe_r && out_run_end_r))
    else $error("item finished without a closing beat");

  // Outstanding packets never exceed the largest effective window.
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding <= SEQ_BITS'(WEFF))
    else $error("outstanding count beyond the window");

  // The retransmit scan never runs past its limit.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RTX_CMP || state_r == S_RTX_FLUSH) |-> (k_r <= lim_r))
    else $error("retransmit scan past its limit");

endmodule
